// ===== hw/rtl/mruq_pkg.sv =====
// ----------------------------------------------------------------------------
// mruq_pkg
// Shared constants and types of the move-to-back queue: sizes, register map,
// and the control bundles passed between the top level and the cell row.
// ----------------------------------------------------------------------------
package mruq_pkg;

    // list storage
    localparam int QUEUE_DEPTH = 256;
    localparam int VAL_W       = 9;
    localparam int POS_W       = 9;
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int WIDE_W      = (LEN_W > POS_W) ? LEN_W : POS_W;

    // read-out tree: cells are ORed in groups, group results are registered
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

    // length register reset, limited to the storage depth
    localparam int LEN_RESET   = (256 > QUEUE_DEPTH) ? QUEUE_DEPTH : 256;

    // configuration port
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam logic REG_QUEUE_LENGTH = 1'b0;   // register index bit paddr[2]

    // control broadcast to every cell
    typedef struct packed {
        logic             fill;
        logic             shift;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last;
        logic [VAL_W-1:0] tail_val;
    } mruq_ctrl_t;

    // configuration event from the register block
    typedef struct packed {
        logic             wr;
        logic [LEN_W-1:0] len;
    } mruq_cfg_t;

endpackage

// ===== hw/rtl/mruq_if.sv =====
// ----------------------------------------------------------------------------
// mruq_req_if / mruq_rsp_if
// Valid/ready channels carrying fetch requests and their results.
// ----------------------------------------------------------------------------
interface mruq_req_if;
    logic                       valid;
    logic                       ready;
    logic [mruq_pkg::POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface mruq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mruq_pkg::VAL_W-1:0] value;
    logic                       error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== hw/rtl/mruq_cell.sv =====
// ----------------------------------------------------------------------------
// mruq_cell
// One list slot: holds a value, refills to its own position, takes its right
// neighbor's value when the list closes up, and takes the fetched value when
// it is the tail.
// ----------------------------------------------------------------------------
module mruq_cell (
    input  logic                             clk,
    input  logic [mruq_pkg::IDX_W-1:0]       slot,
    input  mruq_pkg::mruq_ctrl_t             ctrl,
    input  logic [mruq_pkg::IDX_W-1:0]       look_idx,
    input  logic [mruq_pkg::VAL_W-1:0]       right_val,
    output logic [mruq_pkg::VAL_W-1:0]       val,
    output logic [mruq_pkg::VAL_W-1:0]       sel_val
);

    logic [mruq_pkg::VAL_W-1:0] val_reg;
    logic [mruq_pkg::VAL_W-1:0] val_next;
    logic [mruq_pkg::IDX_W:0]   slot_plus;

    assign slot_plus = {1'b0, slot} + (mruq_pkg::IDX_W + 1)'(1);

    // next slot contents
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.fill)
        begin
            val_next = mruq_pkg::VAL_W'(slot_plus);
        end
        else if (ctrl.shift)
        begin
            if (slot == ctrl.last)
            begin
                val_next = ctrl.tail_val;
            end
            else if (slot >= ctrl.idx && slot < ctrl.last)
            begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // read-out contribution of this slot
    assign val     = val_reg;
    assign sel_val = (slot == look_idx) ? val_reg : '0;

endmodule

// ===== hw/rtl/mruq_cfg.sv =====
// ----------------------------------------------------------------------------
// mruq_cfg
// APB register block holding the queue length, clamped to 1..QUEUE_DEPTH.
// ----------------------------------------------------------------------------
module mruq_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mruq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mruq_pkg::DATA_W-1:0]   pwdata,
    output logic [mruq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mruq_pkg::mruq_cfg_t           cfg
);

    logic [mruq_pkg::LEN_W-1:0]  len_reg;
    logic [mruq_pkg::LEN_W-1:0]  len_next;
    logic [mruq_pkg::WIDE_W-1:0] wdata_wide;
    logic                        wr_hit;

    assign pready     = 1'b1;
    assign wr_hit     = psel && penable && pwrite && (paddr[2] == mruq_pkg::REG_QUEUE_LENGTH);
    assign wdata_wide = mruq_pkg::WIDE_W'(pwdata[mruq_pkg::VAL_W-1:0]);

    // clamp written length into range
    always_comb
    begin
        len_next = len_reg;
        if (wr_hit)
        begin
            priority if (wdata_wide == '0)
            begin
                len_next = mruq_pkg::LEN_W'(1);
            end
            else if (wdata_wide > mruq_pkg::WIDE_W'(mruq_pkg::QUEUE_DEPTH))
            begin
                len_next = mruq_pkg::LEN_W'(mruq_pkg::QUEUE_DEPTH);
            end
            else
            begin
                len_next = mruq_pkg::LEN_W'(wdata_wide);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= mruq_pkg::LEN_W'(mruq_pkg::LEN_RESET);
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // read back
    assign prdata = (paddr[2] == mruq_pkg::REG_QUEUE_LENGTH)
                    ? mruq_pkg::DATA_W'(len_reg) : '0;

    assign cfg.wr  = wr_hit;
    assign cfg.len = len_reg;

endmodule

// ===== hw/rtl/mru_queue_fetch_move_to_end.sv =====
// ----------------------------------------------------------------------------
// mru_queue_fetch_move_to_end
// Ordered list of queue_length values; each request fetches the value at a
// one-based position and moves it to the tail of the list.
// ----------------------------------------------------------------------------
// Usage:
//   req  (valid/ready): one-based position to fetch.
//   rsp  (valid/ready): the fetched value and an error flag; a position of
//        zero or beyond queue_length gives error with value zero and leaves
//        the list as it was.
//   APB: register 0 at address 0 is queue_length (1..256, reset 256). A write
//        refills the list with 1..N; write only while the block is idle.
// Operation:
//   The list lives in a row of cells, one per slot. When a request is accepted,
//   the first level of a two-level OR tree (16 groups of 16 cells) is registered.
//   In the second step the group results are ORed, the cells from the fetched
//   slot to the tail shift at once, and the result is registered, setting
//   rsp.valid. A new request is taken only after that second step.
// Reset and stall:
//   After rst_n rises the cells fill themselves while a fill is pending; req.ready
//   stays low during it. While rsp is stalled the second step waits, and a
//   new request is taken only once that step has completed.
// ----------------------------------------------------------------------------
module mru_queue_fetch_move_to_end (
    input  logic                          clk,
    input  logic                          rst_n,
    mruq_req_if.sink                      req,
    mruq_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mruq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mruq_pkg::DATA_W-1:0]   pwdata,
    output logic [mruq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    mruq_pkg::mruq_cfg_t  cfg;
    mruq_pkg::mruq_ctrl_t ctrl;

    logic                          fill_pending_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic [mruq_pkg::IDX_W-1:0]    idx_reg;
    logic                          err_reg;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [mruq_pkg::VAL_W-1:0]    rsp_value_reg;
    logic                          rsp_error_reg;

    logic                          req_xfer;
    logic                          out_free;
    logic                          step2;
    logic [mruq_pkg::WIDE_W-1:0]   pos_wide;
    logic [mruq_pkg::WIDE_W-1:0]   pos_m1;
    logic [mruq_pkg::WIDE_W-1:0]   len_wide;
    logic [mruq_pkg::LEN_W-1:0]    len_m1;
    logic                          req_err;
    logic [mruq_pkg::IDX_W-1:0]    look_idx;
    logic [mruq_pkg::VAL_W-1:0]    fetched;

    logic [mruq_pkg::VAL_W-1:0]    cell_val [mruq_pkg::QUEUE_DEPTH];
    logic [mruq_pkg::VAL_W-1:0]    cell_sel [mruq_pkg::PAD_DEPTH];
    logic [mruq_pkg::VAL_W-1:0]    group_reg [mruq_pkg::NUM_GROUPS];
    logic [mruq_pkg::VAL_W-1:0]    group_next [mruq_pkg::NUM_GROUPS];

    // configuration registers
    mruq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // request decode
    assign pos_wide = mruq_pkg::WIDE_W'(req.position);
    assign pos_m1   = pos_wide - mruq_pkg::WIDE_W'(1);
    assign len_wide = mruq_pkg::WIDE_W'(cfg.len);
    assign len_m1   = cfg.len - mruq_pkg::LEN_W'(1);
    assign req_err  = (pos_wide == '0) || (pos_wide > len_wide);
    assign look_idx = pos_m1[mruq_pkg::IDX_W-1:0];

    // handshake
    assign req.ready = !fill_pending_reg && !busy_reg;
    assign req_xfer  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign step2     = busy_reg && out_free;

    // final OR over the registered group results
    always_comb
    begin
        fetched = '0;
        for (int g = 0; g < mruq_pkg::NUM_GROUPS; g++)
        begin
            fetched = fetched | group_reg[g];
        end
    end

    // control broadcast to the cell row
    assign ctrl.fill     = fill_pending_reg || cfg.wr;
    assign ctrl.shift    = step2 && !err_reg;
    assign ctrl.idx      = idx_reg;
    assign ctrl.last     = len_m1[mruq_pkg::IDX_W-1:0];
    assign ctrl.tail_val = fetched;

    // row of cells, each fed by its right neighbor
    for (genvar i = 0; i < mruq_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        logic [mruq_pkg::VAL_W-1:0] right_val;
        if (i == mruq_pkg::QUEUE_DEPTH - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = cell_val[i+1];
        end

        mruq_cell u_cell (
            .clk       (clk),
            .slot      (mruq_pkg::IDX_W'(i)),
            .ctrl      (ctrl),
            .look_idx  (look_idx),
            .right_val (right_val),
            .val       (cell_val[i]),
            .sel_val   (cell_sel[i])
        );
    end

    // padding slots of the read-out tree
    for (genvar i = mruq_pkg::QUEUE_DEPTH; i < mruq_pkg::PAD_DEPTH; i++)
    begin : g_pad
        assign cell_sel[i] = '0;
    end

    // first level of the read-out tree
    for (genvar g = 0; g < mruq_pkg::NUM_GROUPS; g++)
    begin : g_group
        always_comb
        begin
            group_next[g] = '0;
            for (int k = 0; k < mruq_pkg::GROUP_SIZE; k++)
            begin
                group_next[g] = group_next[g] | cell_sel[g*mruq_pkg::GROUP_SIZE + k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (req_xfer)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            idx_reg <= look_idx;
            err_reg <= req_err;
        end
    end

    // control flags
    always_comb
    begin
        busy_next = busy_reg;
        if (req_xfer)
        begin
            busy_next = 1'b1;
        end
        else if (step2)
        begin
            busy_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (step2)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pending_reg <= 1'b1;
            busy_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            fill_pending_reg <= 1'b0;
            busy_reg         <= busy_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (step2)
        begin
            rsp_value_reg <= err_reg ? '0 : fetched;
            rsp_error_reg <= err_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.value = rsp_value_reg;
    assign rsp.error = rsp_error_reg;

endmodule

// ===== dv/tb_mru_queue_fetch_move_to_end.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mru_queue_fetch_move_to_end
// Self-checking bench for the move-to-tail fetch queue. A directed table
// covers the corner positions and the length register extremes. Random
// phases at several lengths follow, with bursty gaps on both channels.
// A local copy of the list predicts every result, and results are compared
// in order.
// ----------------------------------------------------------------------------
module tb_mru_queue_fetch_move_to_end;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int REPORT_MAX     = 10;

    // register map
    localparam logic [mruq_pkg::ADDR_W-1:0] A_LEN  = {mruq_pkg::REG_QUEUE_LENGTH, 2'b00};
    localparam logic [mruq_pkg::ADDR_W-1:0] A_NONE = {~mruq_pkg::REG_QUEUE_LENGTH, 2'b00};

    typedef struct packed {
        logic [mruq_pkg::VAL_W-1:0] value;
        logic                       error;
    } fetch_t;

    typedef enum logic [0:0] {ROW_FETCH, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [mruq_pkg::ADDR_W-1:0] addr;
        logic [mruq_pkg::DATA_W-1:0] data;    // position for a fetch row
        logic                        known;   // result typed in below
        logic [mruq_pkg::VAL_W-1:0]  value;
        logic                        error;
    } step_t;

    // directed table: corner positions, then the length register extremes
    step_t directed_steps [0:24] = '{
        '{ROW_FETCH, A_LEN,  32'd256,        1'b1, 9'd256, 1'b0},  // tail after reset
        '{ROW_FETCH, A_LEN,  32'd0,          1'b1, 9'd0,   1'b1},
        '{ROW_FETCH, A_LEN,  32'd257,        1'b1, 9'd0,   1'b1},
        '{ROW_FETCH, A_LEN,  32'd511,        1'b1, 9'd0,   1'b1},
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd1,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd2,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd255,        1'b1, 9'd1,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd128,        1'b0, 9'd0,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd170,        1'b0, 9'd0,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd85,         1'b0, 9'd0,   1'b0},
        '{ROW_WRITE, A_NONE, 32'd5,          1'b0, 9'd0,   1'b0},  // unmapped, no refill
        '{ROW_FETCH, A_LEN,  32'd1,          1'b0, 9'd0,   1'b0},
        '{ROW_WRITE, A_LEN,  32'd1,          1'b0, 9'd0,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd1,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd2,          1'b1, 9'd0,   1'b1},
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd1,   1'b0},
        '{ROW_WRITE, A_LEN,  32'd0,          1'b0, 9'd0,   1'b0},  // saturates to one
        '{ROW_FETCH, A_LEN,  32'd2,          1'b1, 9'd0,   1'b1},
        '{ROW_WRITE, A_LEN,  32'd300,        1'b0, 9'd0,   1'b0},  // saturates to depth
        '{ROW_FETCH, A_LEN,  32'd256,        1'b1, 9'd256, 1'b0},
        '{ROW_FETCH, A_LEN,  32'd257,        1'b1, 9'd0,   1'b1},
        '{ROW_WRITE, A_LEN,  32'hFFFF_FE02,  1'b0, 9'd0,   1'b0},  // upper bits dropped
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd1,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd1,          1'b1, 9'd2,   1'b0},
        '{ROW_FETCH, A_LEN,  32'd3,          1'b1, 9'd0,   1'b1}
    };

    int phase_lens [0:NUM_PHASES-1] = '{256, 1, 2, 17, 0, 255, 5, 256};

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mruq_pkg::ADDR_W-1:0]   paddr;
    logic [mruq_pkg::DATA_W-1:0]   pwdata;
    logic [mruq_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    mruq_req_if req_ch ();
    mruq_rsp_if rsp_ch ();

    mru_queue_fetch_move_to_end dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the list and its length
    logic [mruq_pkg::VAL_W-1:0] slot_vals [mruq_pkg::QUEUE_DEPTH];
    int                         list_len;
    fetch_t                     fetched_values [$];

    int  mismatch_cnt;
    int  fetches_sent;
    int  bad_positions;
    int  results_seen;
    int  length_writes;
    int  cycle_cnt;
    bit  quiet_tail;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic void refill(int len);
        list_len = len;
        for (int p = 0; p < mruq_pkg::QUEUE_DEPTH; p++)
            slot_vals[p] = mruq_pkg::VAL_W'(p + 1);
    endfunction

    function automatic int clamp_len(logic [mruq_pkg::DATA_W-1:0] d);
        logic [mruq_pkg::VAL_W-1:0] v;
        v = d[mruq_pkg::VAL_W-1:0];
        if (v == '0)
            return 1;
        if (int'(v) > mruq_pkg::QUEUE_DEPTH)
            return mruq_pkg::QUEUE_DEPTH;
        return int'(v);
    endfunction

    // fetch at a one-based position and rotate that value to the tail
    function automatic fetch_t move_to_tail(logic [mruq_pkg::POS_W-1:0] pos);
        fetch_t                     r;
        logic [mruq_pkg::VAL_W-1:0] v;
        if (pos == '0 || int'(pos) > list_len)
        begin
            r.value = '0;
            r.error = 1'b1;
            return r;
        end
        v = slot_vals[int'(pos) - 1];
        for (int i = int'(pos) - 1; i < list_len - 1; i++)
            slot_vals[i] = slot_vals[i + 1];
        slot_vals[list_len - 1] = v;
        r.value = v;
        r.error = 1'b0;
        return r;
    endfunction

    function automatic logic [mruq_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 10)
            return mruq_pkg::POS_W'(list_len + 1);
        if (r < 14)
            return mruq_pkg::POS_W'($urandom_range(list_len + 1,
                                                   (1 << mruq_pkg::POS_W) - 1));
        if (r < 20)
            return mruq_pkg::POS_W'(list_len);
        return mruq_pkg::POS_W'($urandom_range(1, list_len));
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // random sender gap
    task automatic req_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            repeat (n)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
    endtask

    // one request transfer, predicted on acceptance
    task automatic send_fetch(logic [mruq_pkg::POS_W-1:0] pos, logic known,
                              logic [mruq_pkg::VAL_W-1:0] kval, logic kerr);
        fetch_t got;
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.position <= pos;
        do @(posedge clk); while (!req_ch.ready);
        got = move_to_tail(pos);
        if (got.error)
            bad_positions++;
        if (known)
        begin
            got.value = kval;
            got.error = kerr;
        end
        fetched_values.push_back(got);
        fetches_sent++;
    endtask

    // hold off requests until every pending result is back
    task automatic drain_fetches();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (fetched_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [mruq_pkg::ADDR_W-1:0] addr,
                              logic [mruq_pkg::DATA_W-1:0] data,
                              output logic [mruq_pkg::DATA_W-1:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register write while idle, with read-back of the length
    task automatic write_reg(logic [mruq_pkg::ADDR_W-1:0] addr,
                             logic [mruq_pkg::DATA_W-1:0] data);
        logic [mruq_pkg::DATA_W-1:0] rd;
        drain_fetches();
        apb_access(1'b1, addr, data, rd);
        if (addr == A_LEN)
        begin
            refill(clamp_len(data));
            length_writes++;
            apb_access(1'b0, addr, '0, rd);
            if (rd !== mruq_pkg::DATA_W'(list_len))
                flag_mismatch($sformatf("queue_length read %0d, expected %0d",
                                        rd, list_len));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        fetch_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (fetched_values.size() == 0)
                flag_mismatch($sformatf("result value %0d error %0b with nothing pending",
                                        rsp_ch.value, rsp_ch.error));
            else
            begin
                want = fetched_values[0];
                fetched_values.delete(0);
                if (rsp_ch.value !== want.value)
                    flag_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_ch.value, want.value));
                if (rsp_ch.error !== want.error)
                    flag_mismatch($sformatf("error %0b, expected %0b",
                                            rsp_ch.error, want.error));
            end
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        int run;
        int gap;
        rsp_ch.ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0)
                run = 60;
            repeat (run)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            if (!quiet_tail)
            begin
                gap = $urandom_range(1, 19);
                repeat (gap)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
        end
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, fetched_values.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [mruq_pkg::DATA_W-1:0] wdata;
        int                          wlen;
        step_t                       row;
        mismatch_cnt    = 0;
        fetches_sent    = 0;
        bad_positions   = 0;
        results_seen    = 0;
        length_writes   = 0;
        quiet_tail      = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.position = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;
        refill(clamp_len(mruq_pkg::DATA_W'(mruq_pkg::LEN_RESET)));
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_steps[i])
        begin
            row = directed_steps[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.addr, row.data);
            else
            begin
                req_gap();
                send_fetch(row.data[mruq_pkg::POS_W-1:0], row.known, row.value, row.error);
            end
        end

        // random phases at a spread of lengths, last one without idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wlen = (phase_lens[ph] == 0) ? $urandom_range(3, 250) : phase_lens[ph];
            wdata = mruq_pkg::DATA_W'(wlen);
            if ($urandom_range(0, 1) == 1)
                wdata = ($urandom() & ~mruq_pkg::DATA_W'((1 << mruq_pkg::VAL_W) - 1))
                        | mruq_pkg::DATA_W'(wlen);
            write_reg(A_LEN, wdata);
            if (ph == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                req_gap();
                send_fetch(pick_position(), 1'b0, '0, 1'b0);
                if (ph == 3 && k == ITEMS_PER_PHASE / 2)
                    drain_fetches();
            end
        end

        drain_fetches();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (fetched_values.size() != 0)
            $display("%0d expected results never arrived", fetched_values.size());
        $display("covered %0d fetches (%0d with a bad position) over %0d length writes",
                 fetches_sent, bad_positions, length_writes);
        $display("checked %0d results, %0d mismatches", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && fetched_values.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mruq_pkg.sv
hw/rtl/mruq_if.sv
hw/rtl/mruq_cell.sv
hw/rtl/mruq_cfg.sv
hw/rtl/mru_queue_fetch_move_to_end.sv
dv/tb_mru_queue_fetch_move_to_end.sv
